### sv/mfac_pkg.sv
// Shared types, codes and fixed-point helpers of the model-free adaptive controller.
`default_nettype none

package mfac_pkg;

    localparam int Q_W      = 32;
    localparam int SUM_W    = 48;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [Q_W-1:0]   t_q;
    typedef logic signed [SUM_W-1:0] t_sum;

    localparam logic [1:0] CMD_STEP      = 2'd0;
    localparam logic [1:0] CMD_LOAD_W    = 2'd1;
    localparam logic [1:0] CMD_LOAD_INIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EST_DAMPING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTL_DAMPING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ORDER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IN_ORDER    = 3'd5;

    localparam t_q Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic start;
        t_sum num;
        t_sum den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_q   quo;
    } t_div_rsp;

    function automatic t_sum ext_q(input t_q v);
        ext_q = {{(SUM_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic t_sum ext_u31(input logic [30:0] v);
        ext_u31 = {{(SUM_W-31){1'b0}}, v};
    endfunction

    function automatic t_q sat_q(input t_sum v);
        if (v > ext_q(Q_MAX)) begin
            sat_q = Q_MAX;
        end else if (v < ext_q(Q_MIN)) begin
            sat_q = Q_MIN;
        end else begin
            sat_q = v[Q_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### sv/model_free_adaptive_controller.sv
// Full-form model-free adaptive controller: sequencer, tables and registers.
//
// Usage: the slave stream carries one item per transfer. tuser holds cmd
// (0 control step, 1 load weight entry, 2 load initial estimate entry).
// A load writes its table entry in the transfer cycle and keeps the input
// ready; it gives no result. Index at or above MAX_ORDER and cmd 3 are dropped.
// A control step drops ready and runs a sequencer over one shared multiplier
// and one bit-serial divider: the history energies, the projection update
// (one division per entry), an estimate restore when needed, the control
// sums, one more division and the history shift, with loops over the
// active history length.
// The divider (one quotient bit per cycle) sets most of the step's length.
// The result goes to an output register on the master stream: tdata the
// control value, tuser the restore flag. A stalled receiver holds it there;
// the block still takes loads and starts the next step, which waits at its
// end until the register frees.
// Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_wr_en
// is high, only while the block is idle.
// Reset (synchronous, active low) clears every table, the history, the
// previous values and the registers to their defaults, and empties the
// output register.
`default_nettype none

module model_free_adaptive_controller #(
    parameter int MAX_ORDER = 20,
    parameter int FRAC_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // [4:0] entry_index, [36:5] entry_value, [68:37] measured,
    // [100:69] target, [103:101] zero
    input  wire logic [103:0] i_s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [31:0] control_value
    output logic [31:0]       o_m_tdata,
    // [0] estimate_was_reset
    output logic [0:0]        o_m_tuser
);

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam logic [5:0] IDX_LIM = 6'(MAX_ORDER);
    localparam int ETA_MIN_I = (((1 << FRAC_BITS) + 5000) / 10000 < 1) ? 1
                               : ((1 << FRAC_BITS) + 5000) / 10000;
    localparam mfac_pkg::t_q ETA_MIN = 32'(ETA_MIN_I);
    localparam mfac_pkg::t_q ETA_MAX = 32'(2 << FRAC_BITS);

    typedef enum logic [5:0] {
        S_IDLE, S_A_RD, S_A_M1, S_A_M2, S_A_ACC, S_A_END,
        S_B_RD, S_B_M1, S_B_M2, S_B_DIV, S_B_WAIT, S_B_M3, S_B_ACC,
        S_R_CHK, S_C_RD, S_C_WR,
        S_P_RD, S_P1, S_P2, S_P3, S_P4,
        S_T_RD, S_T1, S_T2, S_T3, S_T4,
        S_N_RD, S_N1, S_N2, S_N3, S_N4, S_N_WAIT,
        S_D_RD, S_D_WR, S_D_Y, S_D_U, S_OUT
    } t_state;

    // configuration
    mfac_pkg::t_q r_step_gain;
    logic [30:0]  r_mu;
    logic [30:0]  r_lambda;
    logic [30:0]  r_eps;
    logic [3:0]   r_ny_cfg;
    logic [3:0]   r_nx_cfg;

    // tables and history
    mfac_pkg::t_q r_grad [MAX_ORDER];
    mfac_pkg::t_q r_init [MAX_ORDER];
    mfac_pkg::t_q r_wgt  [MAX_ORDER];
    mfac_pkg::t_q r_hist [MAX_ORDER];
    mfac_pkg::t_q r_rd_g, r_rd_i, r_rd_w, r_rd_h;

    // sequencer
    t_state          r_state;
    logic [CW-1:0]   r_k;
    logic [CW-1:0]   r_n;
    logic [AW-1:0]   r_ny;
    mfac_pkg::t_q    r_eta, r_dy, r_e2, r_err, r_ng, r_gny, r_ctl, r_meas;
    mfac_pkg::t_q    r_prev_ctl, r_prev_meas;
    mfac_pkg::t_sum  r_sq, r_dph, r_den, r_sqp, r_mm, r_num;
    logic            r_was_reset;
    logic            r_ov;
    logic [31:0]     r_odata;
    logic            r_ouser;

    // input fields
    logic [1:0]      in_cmd;
    logic [4:0]      in_idx;
    mfac_pkg::t_q    in_val, in_meas, in_tgt;
    logic            in_acc;
    logic            load_ok;

    // derived step values
    int              ny_v, nx_v, n_v;
    mfac_pkg::t_q    eta_v;

    // shared units
    mfac_pkg::t_q    mul_a, mul_b, mul_p;
    mfac_pkg::t_div_req div_req;
    mfac_pkg::t_div_rsp div_rsp;

    // table ports
    logic [AW-1:0]   ra_g, ra_i, ra_w, ra_h;
    logic            we_g, we_h;
    logic [AW-1:0]   wa_g, wa_h;
    mfac_pkg::t_q    wd_g, wd_h;
    mfac_pkg::t_q    new_g;
    logic            reset_hit;

    assign in_cmd  = i_s_tuser;
    assign in_idx  = i_s_tdata[4:0];
    assign in_val  = i_s_tdata[36:5];
    assign in_meas = i_s_tdata[68:37];
    assign in_tgt  = i_s_tdata[100:69];
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign load_ok = in_acc && ({1'b0, in_idx} < IDX_LIM);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    // limit the orders and clamp the estimator step
    always_comb begin
        ny_v = (int'(r_ny_cfg) > MAX_ORDER - 1) ? MAX_ORDER - 1 : int'(r_ny_cfg);
        nx_v = (r_nx_cfg == 4'd0) ? 1 : int'(r_nx_cfg);
        n_v  = (ny_v + nx_v > MAX_ORDER) ? MAX_ORDER : ny_v + nx_v;
        if (r_step_gain <= 0) begin
            eta_v = ETA_MIN;
        end else if (r_step_gain > ETA_MAX) begin
            eta_v = ETA_MAX;
        end else begin
            eta_v = r_step_gain;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_gain <= 32'sd65536;
            r_mu        <= 31'd65536;
            r_lambda    <= 31'd65536;
            r_eps       <= 31'd1;
            r_ny_cfg    <= 4'd1;
            r_nx_cfg    <= 4'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mfac_pkg::REG_STEP_GAIN:   r_step_gain <= i_cfg_wdata;
                mfac_pkg::REG_EST_DAMPING: r_mu        <= i_cfg_wdata[30:0];
                mfac_pkg::REG_CTL_DAMPING: r_lambda    <= i_cfg_wdata[30:0];
                mfac_pkg::REG_RESET_THR:   r_eps       <= i_cfg_wdata[30:0];
                mfac_pkg::REG_OUT_ORDER:   r_ny_cfg    <= i_cfg_wdata[3:0];
                mfac_pkg::REG_IN_ORDER:    r_nx_cfg    <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_A_M1: begin mul_a = r_rd_h; mul_b = r_rd_h; end
            S_A_M2: begin mul_a = r_rd_g; mul_b = r_rd_h; end
            S_B_M1: begin mul_a = r_eta;  mul_b = r_rd_h; end
            S_B_M2: begin mul_a = mul_p;  mul_b = r_err;  end
            S_B_M3: begin mul_a = r_ng;   mul_b = r_ng;   end
            S_P1:   begin mul_a = r_gny;  mul_b = r_rd_w; end
            S_P2:   begin mul_a = mul_p;  mul_b = r_rd_g; end
            S_P3:   begin mul_a = mul_p;  mul_b = r_dy;   end
            S_T1:   begin mul_a = r_gny;  mul_b = r_rd_w; end
            S_T2:   begin mul_a = mul_p;  mul_b = r_rd_g; end
            S_T3:   begin mul_a = mul_p;  mul_b = r_rd_h; end
            S_N1:   begin mul_a = r_rd_w; mul_b = r_gny;  end
            S_N2:   begin mul_a = mul_p;  mul_b = r_e2;   end
            S_N3:   begin mul_a = r_gny;  mul_b = r_gny;  end
            default: ;
        endcase
    end

    mfac_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        if (r_state == S_B_DIV) begin
            div_req.start = 1'b1;
            div_req.num   = mfac_pkg::ext_q(mul_p);
            div_req.den   = r_den;
        end else if (r_state == S_N4) begin
            div_req.start = 1'b1;
            div_req.num   = r_num;
            div_req.den   = mfac_pkg::ext_u31(r_lambda) + mfac_pkg::ext_q(mul_p);
        end
    end

    mfac_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // table addresses and write ports
    always_comb begin
        ra_g = AW'(r_k);
        ra_i = r_ny;
        ra_w = AW'(r_k);
        ra_h = AW'(r_k);
        if (r_state inside {S_T_RD, S_T1, S_T2}) begin
            ra_g = AW'(r_k + CW'(1));
        end
        if (r_state == S_C_RD) begin
            ra_i = AW'(r_k);
        end
        if (r_state == S_N_RD) begin
            ra_w = r_ny;
        end
        if (r_state == S_D_RD) begin
            ra_h = AW'(r_k - CW'(1));
        end

        new_g = mfac_pkg::sat_q(mfac_pkg::ext_q(r_rd_g) + mfac_pkg::ext_q(div_rsp.quo));

        we_g = 1'b0;
        wa_g = AW'(r_k);
        wd_g = new_g;
        if (load_ok && in_cmd == mfac_pkg::CMD_LOAD_INIT) begin
            we_g = 1'b1;
            wa_g = in_idx[AW-1:0];
            wd_g = in_val;
        end else if (r_state == S_B_WAIT && div_rsp.done) begin
            we_g = 1'b1;
        end else if (r_state == S_C_WR) begin
            we_g = 1'b1;
            wd_g = r_rd_i;
        end

        we_h = 1'b0;
        wa_h = AW'(r_k);
        wd_h = r_rd_h;
        case (r_state)
            S_D_WR: we_h = 1'b1;
            S_D_Y: begin
                we_h = 1'b1;
                wa_h = '0;
                wd_h = r_dy;
            end
            S_D_U: begin
                we_h = 1'b1;
                wa_h = r_ny;
                wd_h = mfac_pkg::sat_q(mfac_pkg::ext_q(r_ctl) - mfac_pkg::ext_q(r_prev_ctl));
            end
            default: ;
        endcase

        reset_hit = (r_sqp < mfac_pkg::ext_u31(r_eps)) || (r_gny[31] != r_rd_i[31]);
    end

    // tables: one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_grad[i] <= '0;
                r_init[i] <= '0;
                r_wgt[i]  <= '0;
                r_hist[i] <= '0;
            end
        end else begin
            if (we_g) begin
                r_grad[wa_g] <= wd_g;
            end
            if (load_ok && in_cmd == mfac_pkg::CMD_LOAD_INIT) begin
                r_init[in_idx[AW-1:0]] <= in_val;
            end
            if (load_ok && in_cmd == mfac_pkg::CMD_LOAD_W) begin
                r_wgt[in_idx[AW-1:0]] <= in_val;
            end
            if (we_h) begin
                r_hist[wa_h] <= wd_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_g <= r_grad[ra_g];
        r_rd_i <= r_init[ra_i];
        r_rd_w <= r_wgt[ra_w];
        r_rd_h <= r_hist[ra_h];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_prev_ctl  <= '0;
            r_prev_meas <= '0;
        end else begin
            // load the output register from the last state, or empty it on a transfer
            if (r_state == S_OUT && (!r_ov || i_m_tready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && in_cmd == mfac_pkg::CMD_STEP) begin
                        r_meas  <= in_meas;
                        r_dy    <= mfac_pkg::sat_q(mfac_pkg::ext_q(in_meas)
                                                   - mfac_pkg::ext_q(r_prev_meas));
                        r_e2    <= mfac_pkg::sat_q(mfac_pkg::ext_q(in_tgt)
                                                   - mfac_pkg::ext_q(in_meas));
                        r_eta   <= eta_v;
                        r_ny    <= AW'(ny_v);
                        r_n     <= CW'(n_v);
                        r_k     <= '0;
                        r_sq    <= '0;
                        r_dph   <= '0;
                        r_sqp   <= '0;
                        r_state <= S_A_RD;
                    end
                end
                // history energy and predicted output delta
                S_A_RD: r_state <= S_A_M1;
                S_A_M1: r_state <= S_A_M2;
                S_A_M2: begin
                    r_sq    <= r_sq + mfac_pkg::ext_q(mul_p);
                    r_state <= S_A_ACC;
                end
                S_A_ACC: begin
                    r_dph <= r_dph + mfac_pkg::ext_q(mul_p);
                    if (r_k + CW'(1) == r_n) begin
                        r_state <= S_A_END;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_A_RD;
                    end
                end
                S_A_END: begin
                    r_err   <= mfac_pkg::sat_q(mfac_pkg::ext_q(r_dy) - r_dph);
                    r_den   <= mfac_pkg::ext_u31(r_mu) + r_sq;
                    r_k     <= '0;
                    r_state <= S_B_RD;
                end
                // projection update of the estimate
                S_B_RD:  r_state <= S_B_M1;
                S_B_M1:  r_state <= S_B_M2;
                S_B_M2:  r_state <= S_B_DIV;
                S_B_DIV: r_state <= S_B_WAIT;
                S_B_WAIT: begin
                    if (div_rsp.done) begin
                        r_ng <= new_g;
                        if (AW'(r_k) == r_ny) begin
                            r_gny <= new_g;
                        end
                        r_state <= S_B_M3;
                    end
                end
                S_B_M3: r_state <= S_B_ACC;
                S_B_ACC: begin
                    r_sqp <= r_sqp + mfac_pkg::ext_q(mul_p);
                    if (r_k + CW'(1) == r_n) begin
                        r_state <= S_R_CHK;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_B_RD;
                    end
                end
                // restore on small norm or a sign flip of the gain entry
                S_R_CHK: begin
                    r_was_reset <= reset_hit;
                    r_k         <= '0;
                    if (reset_hit) begin
                        r_gny   <= r_rd_i;
                        r_state <= S_C_RD;
                    end else begin
                        r_state <= S_P_RD;
                    end
                end
                S_C_RD: r_state <= S_C_WR;
                S_C_WR: begin
                    if (r_k + CW'(1) == r_n) begin
                        r_k     <= '0;
                        r_state <= S_P_RD;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_C_RD;
                    end
                end
                // control sums
                S_P_RD: r_state <= S_P1;
                S_P1:   r_state <= S_P2;
                S_P2:   r_state <= S_P3;
                S_P3:   r_state <= S_P4;
                S_P4: begin
                    r_mm <= mfac_pkg::ext_q(mul_p);
                    r_k  <= '0;
                    r_state <= (r_n > CW'(1)) ? S_T_RD : S_N_RD;
                end
                S_T_RD: r_state <= S_T1;
                S_T1:   r_state <= S_T2;
                S_T2:   r_state <= S_T3;
                S_T3:   r_state <= S_T4;
                S_T4: begin
                    r_mm <= r_mm + mfac_pkg::ext_q(mul_p);
                    if (r_k + CW'(2) == r_n) begin
                        r_state <= S_N_RD;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_T_RD;
                    end
                end
                S_N_RD: r_state <= S_N1;
                S_N1:   r_state <= S_N2;
                S_N2:   r_state <= S_N3;
                S_N3: begin
                    r_num   <= mfac_pkg::ext_q(mul_p) - r_mm;
                    r_state <= S_N4;
                end
                S_N4: r_state <= S_N_WAIT;
                S_N_WAIT: begin
                    if (div_rsp.done) begin
                        r_ctl <= mfac_pkg::sat_q(mfac_pkg::ext_q(r_prev_ctl)
                                                 + mfac_pkg::ext_q(div_rsp.quo));
                        if (r_n > CW'(1)) begin
                            r_k     <= r_n - CW'(1);
                            r_state <= S_D_RD;
                        end else begin
                            r_state <= S_D_Y;
                        end
                    end
                end
                // shift the delta history, newest at the front
                S_D_RD: r_state <= S_D_WR;
                S_D_WR: begin
                    if (r_k == CW'(1)) begin
                        r_state <= S_D_Y;
                    end else begin
                        r_k     <= r_k - CW'(1);
                        r_state <= S_D_RD;
                    end
                end
                S_D_Y: r_state <= S_D_U;
                S_D_U: begin
                    r_prev_ctl  <= r_ctl;
                    r_prev_meas <= r_meas;
                    r_state     <= S_OUT;
                end
                // hold until the output register is free
                S_OUT: begin
                    if (!r_ov || i_m_tready) begin
                        r_odata <= r_ctl;
                        r_ouser <= r_was_reset;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/mfac_mul.sv
// Shared fixed-point multiplier: floor shift and saturation, result registered.
`default_nettype none

module mfac_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire mfac_pkg::t_q  i_a,
    input  wire mfac_pkg::t_q  i_b,
    output mfac_pkg::t_q       o_p
);

    logic signed [63:0] prod;
    logic signed [63:0] shifted;
    mfac_pkg::t_q       sat;

    always_comb begin
        prod    = 64'(i_a) * 64'(i_b);
        shifted = prod >>> FRAC_BITS;
        if (shifted > 64'(mfac_pkg::Q_MAX)) begin
            sat = mfac_pkg::Q_MAX;
        end else if (shifted < 64'(mfac_pkg::Q_MIN)) begin
            sat = mfac_pkg::Q_MIN;
        end else begin
            sat = shifted[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_p <= sat;
    end

endmodule

`default_nettype wire

### sv/mfac_div.sv
// Bit-serial restoring divider: (num << FRAC_BITS) / den, toward zero, saturated.
`default_nettype none

module mfac_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mfac_pkg::t_div_req i_req,
    output mfac_pkg::t_div_rsp      o_rsp
);

    localparam int SW = mfac_pkg::SUM_W;
    localparam int DW = SW + FRAC_BITS;
    localparam int IW = $clog2(DW + 1);

    logic            r_busy;
    logic [IW-1:0]   r_cnt;
    logic [DW-1:0]   r_dvd;
    logic [DW-1:0]   r_quo;
    logic [SW-1:0]   r_rem;
    logic [SW-1:0]   r_den;
    logic            r_neg;
    logic            r_done;
    mfac_pkg::t_q    r_q;

    logic [SW:0]     trial;
    logic            fits;
    logic [SW-1:0]   mag;

    always_comb begin
        trial = {r_rem, r_dvd[DW-1]};
        fits  = trial >= {1'b0, r_den};
        mag   = i_req.num[SW-1] ? SW'(-i_req.num) : i_req.num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den[SW-1] || i_req.den == '0) begin
                    // zero or negative divisor: saturate toward the numerator's sign
                    r_done <= 1'b1;
                    if (i_req.num == '0) begin
                        r_q <= '0;
                    end else if (i_req.num[SW-1]) begin
                        r_q <= mfac_pkg::Q_MIN;
                    end else begin
                        r_q <= mfac_pkg::Q_MAX;
                    end
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= IW'(DW);
                    r_dvd  <= {mag, {FRAC_BITS{1'b0}}};
                    r_quo  <= '0;
                    r_rem  <= '0;
                    r_den  <= i_req.den;
                    r_neg  <= i_req.num[SW-1];
                end
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_rem <= fits ? SW'(trial - {1'b0, r_den}) : trial[SW-1:0];
                    r_quo <= {r_quo[DW-2:0], fits};
                    r_dvd <= {r_dvd[DW-2:0], 1'b0};
                    r_cnt <= r_cnt - IW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (!r_neg) begin
                        r_q <= (r_quo > DW'(32'h7FFF_FFFF)) ? mfac_pkg::Q_MAX : r_quo[31:0];
                    end else begin
                        r_q <= (r_quo > DW'(33'h0_8000_0000)) ? mfac_pkg::Q_MIN
                                                               : 32'(-r_quo[31:0]);
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

`default_nettype wire

### sv/mfac_chk.sv
// Port-level checks of the controller and their binding to the top level.
`default_nettype none

module mfac_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic [1:0]   i_s_tuser,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [31:0]  o_m_tdata,
    input wire logic [0:0]   o_m_tuser
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("not idle and empty after reset");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == mfac_pkg::CMD_STEP |=> !o_s_tready)
        else $error("step transfer did not start the sequencer");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser != mfac_pkg::CMD_STEP |=> o_s_tready)
        else $error("load transfer blocked the input");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared without a step in progress");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind model_free_adaptive_controller mfac_chk u_mfac_chk (.*);

`default_nettype wire
